[rtl/core/kce_pkg.sv]
// ----------------------------------------------------------------------------
// kce_pkg
// Shared widths, defaults, register indexes and control types of the
// k-combination enumerator.
// ----------------------------------------------------------------------------
package kce_pkg;

  // field and state widths
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned MASK_W = 64;
  localparam int unsigned SEQ_W  = 64;

  // default number of cells
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // register reset values
  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RST = CNT_W'(8);
  localparam logic [CNT_W-1:0] SELECT_COUNT_RST  = CNT_W'(4);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ELEMENT_COUNT = 1'b0,
    REG_SELECT_COUNT  = 1'b1
  } kce_reg_e;

  // per-cycle control broadcast to the cell row
  typedef struct packed {
    logic             load_first;
    logic             advance;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
  } kce_ctrl_t;

endpackage

[rtl/core/k_combination_enumerator_top.sv]
// ----------------------------------------------------------------------------
// k_combination_enumerator_top
// Lexicographic k-combination generator built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write element_count (n) and select_count (k) through cfg_we_i,
//   cfg_index_i and cfg_data_i while the block is idle. Each input item
//   carries restart_i: 1 gives the first combination, 0 the next one.
//   Every item yields exactly one result item: member_mask_o, ordinal_o,
//   is_last_o and exhausted_o (set, with the other fields zero, when no
//   combination exists: k > n, advance after the last one or before any
//   restart).
//   An accepted item passes the stage one register, then the output
//   register that raises out_valid_o. One item is taken per cycle while
//   no result is held: the slot cells find the pivot through the priority
//   chain running across the cell row and refill as the item is taken.
//   When out_stall_i holds a result, at most one more item is taken into
//   the middle stage, then in_stall_o rises until the result moves on.
//   Reset loads n = 8, k = 4, clears the slots and leaves the block with
//   no combination started; it needs no clearing pass.
// ----------------------------------------------------------------------------
module k_combination_enumerator_top #(
  parameter int unsigned MAX_ELEMENTS = kce_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [kce_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kce_pkg::MASK_W-1:0]  member_mask_o,
  output logic [kce_pkg::SEQ_W-1:0]   ordinal_o,
  output logic                        is_last_o,
  output logic                        exhausted_o
);

  localparam logic [kce_pkg::CNT_W-1:0] MAX_C = kce_pkg::CNT_W'(MAX_ELEMENTS);

  logic [kce_pkg::CNT_W-1:0]  element_count_q;
  logic [kce_pkg::CNT_W-1:0]  select_count_q;
  logic [kce_pkg::CNT_W-1:0]  n_eff;
  logic                       k_gt_n;
  logic                       running_q, running_d;
  logic [kce_pkg::SEQ_W-1:0]  seq_q, seq_d;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_cur_q, s1_cur_d;
  logic                       in_fire;
  logic                       s1_move;
  logic                       pivot_found;
  kce_pkg::kce_ctrl_t         ctrl;
  logic [kce_pkg::SLOT_W-1:0] base;
  logic [kce_pkg::MASK_W-1:0] mask_all;
  logic [MAX_ELEMENTS:0]      found;
  logic [MAX_ELEMENTS:0]      past;
  logic [kce_pkg::SLOT_W-1:0] base_part [MAX_ELEMENTS];
  logic [kce_pkg::MASK_W-1:0] mask_part [MAX_ELEMENTS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= kce_pkg::ELEMENT_COUNT_RST;
      select_count_q  <= kce_pkg::SELECT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (kce_pkg::kce_reg_e'(cfg_index_i))
        kce_pkg::REG_ELEMENT_COUNT: element_count_q <= cfg_data_i;
        kce_pkg::REG_SELECT_COUNT:  select_count_q  <= cfg_data_i;
        default:                    element_count_q <= element_count_q;
      endcase
    end
  end

  assign n_eff  = (element_count_q > MAX_C) ? MAX_C : element_count_q;
  assign k_gt_n = select_count_q > n_eff;

  // handshake
  assign s1_move    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_fire    = in_valid_i && !in_stall_o;

  // item decision
  always_comb begin
    ctrl.load_first = 1'b0;
    ctrl.advance    = 1'b0;
    ctrl.n          = n_eff;
    ctrl.k          = select_count_q;
    running_d       = running_q;
    seq_d           = seq_q;
    s1_cur_d        = s1_cur_q;
    s1_valid_d      = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_cur_d   = 1'b0;
      if (restart_i) begin
        if (k_gt_n) begin
          running_d = 1'b0;
        end else begin
          ctrl.load_first = 1'b1;
          seq_d           = '0;
          running_d       = 1'b1;
          s1_cur_d        = 1'b1;
        end
      end else if (!running_q || k_gt_n || !pivot_found) begin
        running_d = 1'b0;
      end else begin
        ctrl.advance = 1'b1;
        seq_d        = seq_q + kce_pkg::SEQ_W'(1);
        s1_cur_d     = 1'b1;
      end
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
      // the combination just given was the last one
      if (s1_cur_q && !pivot_found) begin
        running_d = 1'b0;
      end
    end
  end

  // cell row
  assign found[MAX_ELEMENTS] = 1'b0;
  assign past[0]             = 1'b0;

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    kce_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .found_right_i(found[g+1]),
      .found_left_o (found[g]),
      .past_i       (past[g]),
      .past_o       (past[g+1]),
      .base_i       (base),
      .base_o       (base_part[g]),
      .mask_o       (mask_part[g])
    );
  end

  assign pivot_found = found[0];

  // gather pivot base and membership bits
  always_comb begin
    base     = '0;
    mask_all = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      base     = base | base_part[i];
      mask_all = mask_all | mask_part[i];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      seq_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_cur_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      running_q  <= running_d;
      seq_q      <= seq_d;
      s1_valid_q <= s1_valid_d;
      s1_cur_q   <= s1_cur_d;
      if (s1_move) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // output register, filled from the slots of the item in stage one
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      if (s1_cur_q) begin
        member_mask_o <= mask_all;
        ordinal_o     <= seq_q;
        is_last_o     <= !pivot_found;
        exhausted_o   <= 1'b0;
      end else begin
        member_mask_o <= '0;
        ordinal_o     <= '0;
        is_last_o     <= 1'b0;
        exhausted_o   <= 1'b1;
      end
    end
  end

  // an exhausted result carries no combination
  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> member_mask_o == '0 && ordinal_o == '0 && !is_last_o)
    else $error("exhausted result with nonzero fields");

  // an unblocked item in stage one reaches the output
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !in_stall_o |=> out_valid_o)
    else $error("stage one item lost");

  // a valid restart starts at ordinal zero with a combination pending
  a_restart_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && restart_i && !k_gt_n |=> s1_valid_q && s1_cur_q && seq_q == '0)
    else $error("restart did not load the first combination");

endmodule

[rtl/core/kce_cell.sv]
// ----------------------------------------------------------------------------
// kce_cell
// One slot of the combination: holds its index, flags itself as a pivot
// candidate and passes search flags to its neighbors.
// ----------------------------------------------------------------------------
module kce_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kce_pkg::kce_ctrl_t              ctrl_i,
  input  logic                            found_right_i,
  output logic                            found_left_o,
  input  logic                            past_i,
  output logic                            past_o,
  input  logic [kce_pkg::SLOT_W-1:0]      base_i,
  output logic [kce_pkg::SLOT_W-1:0]      base_o,
  output logic [kce_pkg::MASK_W-1:0]      mask_o
);

  localparam logic [kce_pkg::SLOT_W-1:0] IDX_S   = kce_pkg::SLOT_W'(IDX);
  localparam logic [kce_pkg::CNT_W-1:0]  IDX_C   = kce_pkg::CNT_W'(IDX);
  localparam logic [kce_pkg::SLOT_W-1:0] SLOT_W1 = kce_pkg::SLOT_W'(1);

  logic [kce_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic                       in_use;
  logic                       below;
  logic                       is_pivot;
  logic [kce_pkg::CNT_W:0]    lhs;
  logic [kce_pkg::CNT_W:0]    rhs;

  // slot below its limit: slot + k < n + idx
  assign in_use   = IDX_C < ctrl_i.k;
  assign lhs      = (kce_pkg::CNT_W+1)'(slot_q) + (kce_pkg::CNT_W+1)'(ctrl_i.k);
  assign rhs      = (kce_pkg::CNT_W+1)'(ctrl_i.n) + (kce_pkg::CNT_W+1)'(IDX_C);
  assign below    = in_use && (lhs < rhs);
  assign is_pivot = below && !found_right_i;

  // search chains toward both neighbors
  assign found_left_o = found_right_i || below;
  assign past_o       = past_i || is_pivot;

  // refill base offered by the pivot
  assign base_o = is_pivot ? (slot_q + SLOT_W1 - IDX_S) : '0;

  // membership bit
  assign mask_o = in_use ? (kce_pkg::MASK_W'(1) << slot_q) : '0;

  // next slot value
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.load_first && in_use) begin
      slot_d = IDX_S;
    end else if (ctrl_i.advance && in_use && (past_i || is_pivot)) begin
      slot_d = base_i + IDX_S;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

[tb/tb_k_combination_enumerator_top.sv]
// ----------------------------------------------------------------------------
// tb_k_combination_enumerator_top
// Self-checking bench for the k-combination enumerator. A scoreboard class
// keeps its own copy of the slot list, ordinal and counts, predicts each
// result from the accepted items and compares every result field by field.
// Stimulus covers directed corner cases, then random enumerations with random
// restarts, count changes between phases, random idling on both sides and a
// long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_k_combination_enumerator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N        = kce_pkg::MAX_ELEMENTS_DEF;
  localparam int ITEM_TARGET  = 1900;
  localparam int CALM_AFTER   = 1700;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 60;

  // one result item
  typedef struct {
    logic [kce_pkg::MASK_W-1:0] member_mask;
    logic [kce_pkg::SEQ_W-1:0]  ordinal;
    logic                       is_last;
    logic                       exhausted;
  } combo_result_t;

  // predicts results from accepted items and checks them in order
  class combo_scoreboard;
    logic [kce_pkg::CNT_W-1:0]  elem_reg;
    logic [kce_pkg::CNT_W-1:0]  sel_reg;
    logic [kce_pkg::SLOT_W-1:0] slot[MAX_N];
    logic [kce_pkg::SEQ_W-1:0]  seq_no;
    bit                         running;
    combo_result_t              expected_q[$];
    int unsigned                errors;

    function new();
      elem_reg = kce_pkg::ELEMENT_COUNT_RST;
      sel_reg  = kce_pkg::SELECT_COUNT_RST;
      foreach (slot[i]) slot[i] = '0;
      seq_no   = '0;
      running  = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(kce_pkg::kce_reg_e idx, logic [kce_pkg::CNT_W-1:0] value);
      if (idx == kce_pkg::REG_ELEMENT_COUNT) elem_reg = value;
      else sel_reg = value;
    endfunction

    // rightmost slot still below its limit, k when there is none
    function int pivot(int n, int k);
      for (int i = k - 1; i >= 0; i--) begin
        if (int'(slot[i]) < n - k + i) return i;
      end
      return k;
    endfunction

    // result for the current slot list; the last one stops the run
    function combo_result_t current_combo(int n, int k);
      combo_result_t r;
      r.member_mask = '0;
      for (int i = 0; i < k; i++) r.member_mask |= kce_pkg::MASK_W'(1) << slot[i];
      r.ordinal   = seq_no;
      r.is_last   = (pivot(n, k) == k);
      r.exhausted = 1'b0;
      if (r.is_last) running = 1'b0;
      return r;
    endfunction

    function void note_item(bit restart);
      int n;
      int k;
      int p;
      combo_result_t r;
      n = (int'(elem_reg) > MAX_N) ? MAX_N : int'(elem_reg);
      k = int'(sel_reg);
      r.member_mask = '0;
      r.ordinal     = '0;
      r.is_last     = 1'b0;
      r.exhausted   = 1'b1;
      if (restart) begin
        if (k > n) begin
          running = 1'b0;
        end else begin
          for (int i = 0; i < k; i++) slot[i] = kce_pkg::SLOT_W'(i);
          seq_no  = '0;
          running = 1'b1;
          r = current_combo(n, k);
        end
      end else if (running) begin
        if (k > n) begin
          running = 1'b0;
        end else begin
          p = pivot(n, k);
          if (p == k) begin
            running = 1'b0;
          end else begin
            // bump the pivot and refill to its right
            slot[p] = slot[p] + 1'b1;
            for (int i = p + 1; i < k; i++) begin
              slot[i] = slot[p] + kce_pkg::SLOT_W'(i - p);
            end
            seq_no = seq_no + 1'b1;
            r = current_combo(n, k);
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [kce_pkg::MASK_W-1:0] mask,
                               logic [kce_pkg::SEQ_W-1:0] ord,
                               logic last, logic none);
      combo_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item waiting: mask %h ordinal %0d", mask, ord);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (mask !== e.member_mask) begin
        $error("member_mask: expected %h, got %h", e.member_mask, mask);
        errors++;
      end
      if (ord !== e.ordinal) begin
        $error("ordinal: expected %0d, got %0d", e.ordinal, ord);
        errors++;
      end
      if (last !== e.is_last) begin
        $error("is_last: expected %b, got %b", e.is_last, last);
        errors++;
      end
      if (none !== e.exhausted) begin
        $error("exhausted: expected %b, got %b", e.exhausted, none);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic                       cfg_index_i = 1'b0;
  logic [kce_pkg::CNT_W-1:0]  cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       restart_i   = 1'b0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [kce_pkg::MASK_W-1:0] member_mask_o;
  logic [kce_pkg::SEQ_W-1:0]  ordinal_o;
  logic                       is_last_o;
  logic                       exhausted_o;

  combo_scoreboard board = new();
  int unsigned     items_sent = 0;
  int unsigned     busy_pct   = 10;
  bit              calm       = 1'b0;
  bit              hold_request = 1'b0;
  int unsigned     idle_cycles = 0;

  k_combination_enumerator_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .member_mask_o(member_mask_o),
    .ordinal_o    (ordinal_o),
    .is_last_o    (is_last_o),
    .exhausted_o  (exhausted_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one item, return at the edge where it is taken
  task automatic send_item(bit restart);
    if (!calm && $urandom_range(0, 99) < busy_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(restart);
    items_sent++;
  endtask

  // drain the block, then write both counts
  task automatic set_counts(int n, int k);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= kce_pkg::REG_ELEMENT_COUNT;
    cfg_data_i  <= kce_pkg::CNT_W'(n);
    @(posedge clk_i);
    board.write_reg(kce_pkg::REG_ELEMENT_COUNT, kce_pkg::CNT_W'(n));
    cfg_index_i <= kce_pkg::REG_SELECT_COUNT;
    cfg_data_i  <= kce_pkg::CNT_W'(k);
    @(posedge clk_i);
    board.write_reg(kce_pkg::REG_SELECT_COUNT, kce_pkg::CNT_W'(k));
    cfg_we_i <= 1'b0;
  endtask

  // number of combinations, capped
  function automatic int unsigned combo_total(int n, int k);
    longint unsigned c;
    int m;
    if (k > n) return 0;
    m = (k < n - k) ? k : n - k;
    c = 1;
    for (int i = 0; i < m; i++) begin
      c = c * longint'(n - i) / longint'(i + 1);
      if (c > 1000) return 1000;
    end
    return int'(c);
  endfunction

  // result side: random stall bursts, one long hold on request
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < busy_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // check every result taken
  always @(posedge clk_i) begin : result_check
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(member_mask_o, ordinal_o, is_last_o, exhausted_o);
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i ||
        !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("k_combination_enumerator_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int k;
    int len;
    int unsigned total;
    bit carry;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // advance before any restart, then the reset counts n=8 k=4
    send_item(1'b0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // empty set, then advance past the only combination
    set_counts(0, 0);
    send_item(1'b1);
    send_item(1'b0);

    // k above n on restart and on advance
    set_counts(3, 5);
    send_item(1'b1);
    send_item(1'b0);

    // full set of 64
    set_counts(64, 64);
    send_item(1'b1);
    send_item(1'b0);

    // n above the maximum saturates
    set_counts(127, 63);
    send_item(1'b1);
    repeat (2) send_item(1'b0);

    // counts changed while running
    set_counts(10, 3);
    send_item(1'b1);
    send_item(1'b0);
    set_counts(10, 5);
    send_item(1'b0);
    set_counts(6, 5);
    send_item(1'b0);
    set_counts(2, 5);
    send_item(1'b0);

    // long output hold while items keep coming
    set_counts(40, 20);
    hold_request = 1'b1;
    send_item(1'b1);
    repeat (79) send_item(1'b0);

    // random enumerations
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(0, 9);
        6, 7, 8:          n = $urandom_range(10, 64);
        default:          n = $urandom_range(65, 127);
      endcase
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 127);
      else k = $urandom_range(0, (n > MAX_N) ? MAX_N : n);
      total = combo_total((n > MAX_N) ? MAX_N : n, k);
      len = (total + 2 <= 60) ? int'(total) + 2 : $urandom_range(20, 60);
      busy_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      carry = ($urandom_range(0, 9) == 0);
      set_counts(n, k);
      if (len >= 40 && !calm && $urandom_range(0, 14) == 0) hold_request = 1'b1;
      for (int j = 0; j < len; j++) begin
        send_item((j == 0 && !carry) || $urandom_range(0, 39) == 0);
        if (items_sent >= CALM_AFTER) calm = 1'b1;
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("k_combination_enumerator_top regression: pass");
    end else begin
      $display("k_combination_enumerator_top regression: fail");
    end
    $finish;
  end

endmodule
